FILE: rtl/tfs_pkg.sv
`default_nettype none

package tfs_pkg;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_BOTTOM,
      KIND_TOP,
      KIND_SPLIT
   } kind_type;

endpackage

`default_nettype wire

FILE: rtl/triangle_flat_split_top.sv
`default_nettype none
// The first result of a triangle passes the sort, difference, product, divider,
// cut point and output registers; a second result waits in the hold register until shown.
// One triangle per cycle when it gives no or one result and the output is not stalled;
// a split one stalls the pipeline while its second result waits for the output register.
// The cut x divider retires one quotient bit per pipeline stage.
// Reset (synchronous, active high) clears all valid bits; data registers are not reset.

module triangle_flat_split_top #(
   parameter int COORD_WIDTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [COORD_WIDTH-1:0] req_first_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_first_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_second_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_second_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_third_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_third_y,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [COORD_WIDTH-1:0]      rsp_apex_x,
   output logic signed [COORD_WIDTH-1:0]      rsp_apex_y,
   output logic signed [COORD_WIDTH-1:0]      rsp_left_x,
   output logic signed [COORD_WIDTH-1:0]      rsp_left_y,
   output logic signed [COORD_WIDTH-1:0]      rsp_right_x,
   output logic signed [COORD_WIDTH-1:0]      rsp_right_y,
   output logic                               rsp_flipped,
   output logic                               rsp_last
);

   localparam int W = COORD_WIDTH;

   typedef struct packed {
      logic signed [W-1:0] x;
      logic signed [W-1:0] y;
   } vertex_type;

   typedef struct packed {
      vertex_type [2:0]  vtx;
      tfs_pkg::kind_type kind;
      logic              dx_neg;
   } side_type;

   typedef struct packed {
      vertex_type apex;
      vertex_type left;
      vertex_type right;
      logic       flipped;
      logic       last;
   } result_type;

   localparam int SIDE_W = $bits(side_type);

   logic advance;

   // sort
   vertex_type       a0, a1, a2, t;
   logic             st1_valid_ff;
   vertex_type [2:0] st1_vtx_ff;
   vertex_type [2:0] st1_vtx_in;

   always_comb begin
      a0.x = req_first_x;
      a0.y = req_first_y;
      a1.x = req_second_x;
      a1.y = req_second_y;
      a2.x = req_third_x;
      a2.y = req_third_y;
      t    = '0;
      if (a0.y > a1.y) begin
         t  = a0;
         a0 = a1;
         a1 = t;
      end
      if (a1.y > a2.y) begin
         t  = a1;
         a1 = a2;
         a2 = t;
      end
      if (a0.y > a1.y) begin
         t  = a0;
         a0 = a1;
         a1 = t;
      end
      st1_vtx_in = {a2, a1, a0};
   end

   // differences and classification
   logic           st2_valid_ff;
   side_type       st2_side_ff, st2_side_in;
   logic [W-1:0]   st2_dy_mid_ff, st2_dy_mid_in;
   logic [W-1:0]   st2_dy_all_ff, st2_dy_all_in;
   logic [W-1:0]   st2_adx_ff, st2_adx_in;
   logic [W:0]     dy_mid_full, dy_all_full, dx_full, adx_full;
   vertex_type     s0, s1, s2;

   always_comb begin
      s0 = st1_vtx_ff[0];
      s1 = st1_vtx_ff[1];
      s2 = st1_vtx_ff[2];
      dy_mid_full = {s1.y[W-1], s1.y} - {s0.y[W-1], s0.y};
      dy_all_full = {s2.y[W-1], s2.y} - {s0.y[W-1], s0.y};
      dx_full     = {s2.x[W-1], s2.x} - {s0.x[W-1], s0.x};
      adx_full    = dx_full[W] ? -dx_full : dx_full;
      st2_dy_mid_in      = dy_mid_full[W-1:0];
      st2_dy_all_in      = dy_all_full[W-1:0];
      st2_adx_in         = adx_full[W-1:0];
      st2_side_in.vtx    = st1_vtx_ff;
      st2_side_in.dx_neg = dx_full[W];
      if (s0.y == s1.y && s1.y == s2.y) begin
         st2_side_in.kind = tfs_pkg::KIND_NONE;
      end else if (s1.y == s2.y) begin
         st2_side_in.kind = tfs_pkg::KIND_BOTTOM;
      end else if (s0.y == s1.y) begin
         st2_side_in.kind = tfs_pkg::KIND_TOP;
      end else begin
         st2_side_in.kind = tfs_pkg::KIND_SPLIT;
      end
   end

   // product
   logic           st3_valid_ff;
   side_type       st3_side_ff;
   logic [2*W-1:0] st3_prod_ff, st3_prod_in;
   logic [W-1:0]   st3_dy_all_ff;

   assign st3_prod_in = {{W{1'b0}}, st2_dy_mid_ff} * {{W{1'b0}}, st2_adx_ff};

   // division
   logic              div_valid;
   logic [W-1:0]      div_quot;
   logic [SIDE_W-1:0] div_side_vec;
   side_type          div_side;

   tfs_divider #(
      .WIDTH      (W),
      .SIDE_WIDTH (SIDE_W)
   ) u_divider (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (st3_valid_ff),
      .in_product   (st3_prod_ff),
      .in_divisor   (st3_dy_all_ff),
      .in_side      (st3_side_ff),
      .out_valid    (div_valid),
      .out_quotient (div_quot),
      .out_side     (div_side_vec)
   );

   assign div_side = side_type'(div_side_vec);

   // cut point
   logic         st4_valid_ff;
   side_type     st4_side_ff;
   logic [W-1:0] st4_cut_x_ff, st4_cut_x_in;
   logic [W:0]   cut_full, q_ext;

   always_comb begin
      q_ext        = {1'b0, div_quot};
      cut_full     = {div_side.vtx[0].x[W-1], div_side.vtx[0].x}
                     + (div_side.dx_neg ? -q_ext : q_ext);
      st4_cut_x_in = cut_full[W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_valid_ff <= 1'b0;
         st2_valid_ff <= 1'b0;
         st3_valid_ff <= 1'b0;
         st4_valid_ff <= 1'b0;
      end else if (advance) begin
         st1_valid_ff <= req_valid;
         st2_valid_ff <= st1_valid_ff;
         st3_valid_ff <= st2_valid_ff;
         st4_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st1_vtx_ff    <= st1_vtx_in;
         st2_side_ff   <= st2_side_in;
         st2_dy_mid_ff <= st2_dy_mid_in;
         st2_dy_all_ff <= st2_dy_all_in;
         st2_adx_ff    <= st2_adx_in;
         st3_side_ff   <= st2_side_ff;
         st3_prod_ff   <= st3_prod_in;
         st3_dy_all_ff <= st2_dy_all_ff;
         st4_side_ff   <= div_side;
         st4_cut_x_ff  <= st4_cut_x_in;
      end
   end

   // result build
   vertex_type cut_v, ea, eb;
   result_type first_res, second_res;

   always_comb begin
      cut_v.x = st4_cut_x_ff;
      cut_v.y = st4_side_ff.vtx[1].y;
      unique case (st4_side_ff.kind)
         tfs_pkg::KIND_TOP: begin
            ea = st4_side_ff.vtx[0];
            eb = st4_side_ff.vtx[1];
         end
         tfs_pkg::KIND_SPLIT: begin
            ea = cut_v;
            eb = st4_side_ff.vtx[1];
         end
         default: begin
            ea = st4_side_ff.vtx[1];
            eb = st4_side_ff.vtx[2];
         end
      endcase
      if (ea.x >= eb.x) begin
         first_res.left  = eb;
         first_res.right = ea;
      end else begin
         first_res.left  = ea;
         first_res.right = eb;
      end
      first_res.flipped = st4_side_ff.kind == tfs_pkg::KIND_TOP;
      first_res.apex    = first_res.flipped ? st4_side_ff.vtx[2] : st4_side_ff.vtx[0];
      first_res.last    = st4_side_ff.kind != tfs_pkg::KIND_SPLIT;
      second_res         = first_res;
      second_res.apex    = st4_side_ff.vtx[2];
      second_res.flipped = 1'b1;
      second_res.last    = 1'b1;
   end

   // output register and held second result
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;
   logic       hold_valid_ff, hold_valid_in;
   result_type hold_ff, hold_in;
   logic       out_free, take;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign take      = st4_valid_ff && !hold_valid_ff && out_free;
   assign advance   = !st4_valid_ff || take;
   assign req_ready = advance;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      if (hold_valid_ff && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_in        = hold_ff;
         hold_valid_in = 1'b0;
      end else if (take) begin
         rsp_valid_in = st4_side_ff.kind != tfs_pkg::KIND_NONE;
         rsp_in       = first_res;
         if (st4_side_ff.kind == tfs_pkg::KIND_SPLIT) begin
            hold_valid_in = 1'b1;
            hold_in       = second_res;
         end
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      hold_ff <= hold_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_apex_x  = rsp_ff.apex.x;
   assign rsp_apex_y  = rsp_ff.apex.y;
   assign rsp_left_x  = rsp_ff.left.x;
   assign rsp_left_y  = rsp_ff.left.y;
   assign rsp_right_x = rsp_ff.right.x;
   assign rsp_right_y = rsp_ff.right.y;
   assign rsp_flipped = rsp_ff.flipped;
   assign rsp_last    = rsp_ff.last;

   a_hold_has_first: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> rsp_valid_ff)
      else $error("held second result without a first result shown");

   a_first_has_partner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.last |-> hold_valid_ff)
      else $error("non-final result shown without its partner held");

   a_hold_is_top: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> hold_ff.last && hold_ff.flipped)
      else $error("held result is not a final flat-top triangle");

   a_stall_on_hold: assert property (@(posedge clock) disable iff (reset)
      st4_valid_ff && hold_valid_ff |-> !req_ready)
      else $error("pipeline advanced while a second result was pending");

endmodule

`default_nettype wire

FILE: rtl/tfs_divider.sv
`default_nettype none

module tfs_divider #(
   parameter int WIDTH      = 16,
   parameter int SIDE_WIDTH = 1
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    advance,
   input  wire logic                    in_valid,
   input  wire logic [2*WIDTH-1:0]      in_product,
   input  wire logic [WIDTH-1:0]        in_divisor,
   input  wire logic [SIDE_WIDTH-1:0]   in_side,
   output logic                         out_valid,
   output logic [WIDTH-1:0]             out_quotient,
   output logic [SIDE_WIDTH-1:0]        out_side
);

   logic                  valid_w [0:WIDTH];
   logic [WIDTH-1:0]      rem_w   [0:WIDTH];
   logic [WIDTH-1:0]      low_w   [0:WIDTH];
   logic [WIDTH-1:0]      quot_w  [0:WIDTH];
   logic [WIDTH-1:0]      div_w   [0:WIDTH];
   logic [SIDE_WIDTH-1:0] side_w  [0:WIDTH];

   assign valid_w[0] = in_valid;
   assign rem_w[0]   = in_product[2*WIDTH-1:WIDTH];
   assign low_w[0]   = in_product[WIDTH-1:0];
   assign quot_w[0]  = '0;
   assign div_w[0]   = in_divisor;
   assign side_w[0]  = in_side;

   for (genvar s = 0; s < WIDTH; s++) begin : g_step
      logic                  valid_ff;
      logic [WIDTH-1:0]      rem_ff;
      logic [WIDTH-1:0]      rem_in;
      logic [WIDTH-1:0]      low_ff;
      logic [WIDTH-1:0]      quot_ff;
      logic [WIDTH-1:0]      div_ff;
      logic [SIDE_WIDTH-1:0] side_ff;
      logic [WIDTH:0]        trial;
      logic [WIDTH:0]        diff;
      logic                  fits;

      always_comb begin
         trial  = {rem_w[s], low_w[s][WIDTH-1]};
         diff   = trial - {1'b0, div_w[s]};
         fits   = trial >= {1'b0, div_w[s]};
         rem_in = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (advance) begin
            valid_ff <= valid_w[s];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff  <= rem_in;
            low_ff  <= {low_w[s][WIDTH-2:0], 1'b0};
            quot_ff <= {quot_w[s][WIDTH-2:0], fits};
            div_ff  <= div_w[s];
            side_ff <= side_w[s];
         end
      end

      assign valid_w[s+1] = valid_ff;
      assign rem_w[s+1]   = rem_ff;
      assign low_w[s+1]   = low_ff;
      assign quot_w[s+1]  = quot_ff;
      assign div_w[s+1]   = div_ff;
      assign side_w[s+1]  = side_ff;
   end

   assign out_valid    = valid_w[WIDTH];
   assign out_quotient = quot_w[WIDTH];
   assign out_side     = side_w[WIDTH];

endmodule

`default_nettype wire

FILE: tb/triangle_flat_split_checker.sv
`timescale 1ns / 100ps

module triangle_flat_split_checker #(
   parameter int COORD_WIDTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_ready,
   input  wire logic signed [COORD_WIDTH-1:0] req_first_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_first_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_second_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_second_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_third_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_third_y,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire logic signed [COORD_WIDTH-1:0] rsp_apex_x,
   input  wire logic signed [COORD_WIDTH-1:0] rsp_apex_y,
   input  wire logic signed [COORD_WIDTH-1:0] rsp_left_x,
   input  wire logic signed [COORD_WIDTH-1:0] rsp_left_y,
   input  wire logic signed [COORD_WIDTH-1:0] rsp_right_x,
   input  wire logic signed [COORD_WIDTH-1:0] rsp_right_y,
   input  wire logic                          rsp_flipped,
   input  wire logic                          rsp_last,
   output int                                 mismatches,
   output int                                 tris_owed
);

   typedef struct packed {
      logic [COORD_WIDTH-1:0] apex_x;
      logic [COORD_WIDTH-1:0] apex_y;
      logic [COORD_WIDTH-1:0] left_x;
      logic [COORD_WIDTH-1:0] left_y;
      logic [COORD_WIDTH-1:0] right_x;
      logic [COORD_WIDTH-1:0] right_y;
      logic                   flipped;
      logic                   last;
   } tri_type;

   tri_type pending_tris[$];
   int      fails = 0;
   int      tris_left = 0;

   assign mismatches = fails;
   assign tris_owed  = tris_left;

   // the flat-edge vertex a goes right when a.x >= b.x
   function automatic void queue_tri(input longint px, py, ax, ay, bx, by,
                                     input logic flip, fin);
      tri_type t;
      t.apex_x = px[COORD_WIDTH-1:0];
      t.apex_y = py[COORD_WIDTH-1:0];
      if (ax >= bx) begin
         t.left_x  = bx[COORD_WIDTH-1:0];
         t.left_y  = by[COORD_WIDTH-1:0];
         t.right_x = ax[COORD_WIDTH-1:0];
         t.right_y = ay[COORD_WIDTH-1:0];
      end else begin
         t.left_x  = ax[COORD_WIDTH-1:0];
         t.left_y  = ay[COORD_WIDTH-1:0];
         t.right_x = bx[COORD_WIDTH-1:0];
         t.right_y = by[COORD_WIDTH-1:0];
      end
      t.flipped = flip;
      t.last    = fin;
      pending_tris.push_back(t);
   endfunction

   function automatic void split_triangle(
      input logic signed [COORD_WIDTH-1:0] ax, ay, bx, by, cx, cy
   );
      longint            vx[3];
      longint            vy[3];
      longint            tx, ty, dy_mid, dy_all, dx, mag, q, cut_x;
      int                k;
      tfs_pkg::kind_type kind;
      vx[0] = ax;  vy[0] = ay;
      vx[1] = bx;  vy[1] = by;
      vx[2] = cx;  vy[2] = cy;
      // stable sort by y: swap 0/1, then 1/2, then 0/1
      for (int p = 0; p < 3; p++) begin
         k = (p == 1) ? 1 : 0;
         if (vy[k] > vy[k+1]) begin
            tx = vx[k];  ty = vy[k];
            vx[k] = vx[k+1];  vy[k] = vy[k+1];
            vx[k+1] = tx;  vy[k+1] = ty;
         end
      end
      if (vy[0] == vy[1] && vy[1] == vy[2])
         kind = tfs_pkg::KIND_NONE;
      else if (vy[1] == vy[2])
         kind = tfs_pkg::KIND_BOTTOM;
      else if (vy[0] == vy[1])
         kind = tfs_pkg::KIND_TOP;
      else
         kind = tfs_pkg::KIND_SPLIT;
      case (kind)
         tfs_pkg::KIND_BOTTOM:
            queue_tri(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2], 1'b0, 1'b1);
         tfs_pkg::KIND_TOP:
            queue_tri(vx[2], vy[2], vx[0], vy[0], vx[1], vy[1], 1'b1, 1'b1);
         tfs_pkg::KIND_SPLIT: begin
            dy_mid = vy[1] - vy[0];
            dy_all = vy[2] - vy[0];
            dx     = vx[2] - vx[0];
            mag    = (dx < 0) ? -dx : dx;
            q      = (dy_mid * mag) / dy_all;
            cut_x  = (dx < 0) ? vx[0] - q : vx[0] + q;
            queue_tri(vx[0], vy[0], cut_x, vy[1], vx[1], vy[1], 1'b0, 1'b0);
            queue_tri(vx[2], vy[2], cut_x, vy[1], vx[1], vy[1], 1'b1, 1'b1);
         end
         default: ;
      endcase
   endfunction

   function automatic void compare_field(input string field, input longint want,
                                         input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fails++;
      end
   endfunction

   function automatic void check_triangle();
      tri_type want;
      if (pending_tris.size() == 0) begin
         $error("triangle with none owed: apex (%0d,%0d) left (%0d,%0d) right (%0d,%0d)",
                rsp_apex_x, rsp_apex_y, rsp_left_x, rsp_left_y, rsp_right_x, rsp_right_y);
         fails++;
      end else begin
         want = pending_tris.pop_front();
         compare_field("apex_x", $signed(want.apex_x), rsp_apex_x);
         compare_field("apex_y", $signed(want.apex_y), rsp_apex_y);
         compare_field("left_x", $signed(want.left_x), rsp_left_x);
         compare_field("left_y", $signed(want.left_y), rsp_left_y);
         compare_field("right_x", $signed(want.right_x), rsp_right_x);
         compare_field("right_y", $signed(want.right_y), rsp_right_y);
         compare_field("flipped", want.flipped, rsp_flipped);
         compare_field("last", want.last, rsp_last);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            split_triangle(req_first_x, req_first_y, req_second_x, req_second_y,
                           req_third_x, req_third_y);
         if (rsp_valid && rsp_ready)
            check_triangle();
      end
      tris_left <= pending_tris.size();
   end

endmodule

FILE: tb/triangle_flat_split_top_test.sv
`timescale 1ns / 100ps

module triangle_flat_split_top_test;

   localparam int CW          = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_AT     = 200;
   localparam int HOLD_CYCLES = 400;

   typedef logic signed [CW-1:0] coord_type;

   localparam coord_type COORD_MIN = {1'b1, {(CW-1){1'b0}}};
   localparam coord_type COORD_MAX = {1'b0, {(CW-1){1'b1}}};

   logic      clock = 1'b0;
   logic      reset;
   logic      req_valid;
   logic      req_ready;
   coord_type req_first_x, req_first_y, req_second_x, req_second_y;
   coord_type req_third_x, req_third_y;
   logic      rsp_valid;
   logic      rsp_ready;
   coord_type rsp_apex_x, rsp_apex_y, rsp_left_x, rsp_left_y, rsp_right_x, rsp_right_y;
   logic      rsp_flipped;
   logic      rsp_last;
   int        mismatches;
   int        tris_owed;
   int        cycle_count = 0;
   logic      quiet_send = 1'b0;

   always #5 clock = ~clock;

   triangle_flat_split_top #(
      .COORD_WIDTH(CW)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_first_x (req_first_x),
      .req_first_y (req_first_y),
      .req_second_x(req_second_x),
      .req_second_y(req_second_y),
      .req_third_x (req_third_x),
      .req_third_y (req_third_y),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_apex_x  (rsp_apex_x),
      .rsp_apex_y  (rsp_apex_y),
      .rsp_left_x  (rsp_left_x),
      .rsp_left_y  (rsp_left_y),
      .rsp_right_x (rsp_right_x),
      .rsp_right_y (rsp_right_y),
      .rsp_flipped (rsp_flipped),
      .rsp_last    (rsp_last)
   );

   triangle_flat_split_checker #(
      .COORD_WIDTH(CW)
   ) watch (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_first_x (req_first_x),
      .req_first_y (req_first_y),
      .req_second_x(req_second_x),
      .req_second_y(req_second_y),
      .req_third_x (req_third_x),
      .req_third_y (req_third_y),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_apex_x  (rsp_apex_x),
      .rsp_apex_y  (rsp_apex_y),
      .rsp_left_x  (rsp_left_x),
      .rsp_left_y  (rsp_left_y),
      .rsp_right_x (rsp_right_x),
      .rsp_right_y (rsp_right_y),
      .rsp_flipped (rsp_flipped),
      .rsp_last    (rsp_last),
      .mismatches  (mismatches),
      .tris_owed   (tris_owed)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic offer(input coord_type ax, ay, bx, by, cx, cy);
      int gap;
      gap = quiet_send ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_first_x  <= ax;
      req_first_y  <= ay;
      req_second_x <= bx;
      req_second_y <= by;
      req_third_x  <= cx;
      req_third_y  <= cy;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tris_owed != 0) @(posedge clock);
   endtask

   function automatic coord_type near_zero();
      return coord_type'(int'($urandom_range(0, 16)) - 8);
   endfunction

   task automatic offer_random();
      coord_type c[6];
      int        pick, a, b;
      pick = $urandom_range(0, 9);
      for (int i = 0; i < 6; i++)
         c[i] = coord_type'($urandom);
      case (pick)
         4: begin
            a = $urandom_range(0, 2);
            b = (a + $urandom_range(1, 2)) % 3;
            c[2*b+1] = c[2*a+1];
         end
         5: begin
            c[3] = c[1];
            c[5] = c[1];
         end
         6: for (int i = 0; i < 6; i++)
               c[i] = near_zero();
         7: for (int i = 0; i < 6; i++)
               case ($urandom_range(0, 4))
                  0: c[i] = COORD_MIN;
                  1: c[i] = COORD_MAX;
                  2: c[i] = '0;
                  3: c[i] = '1;
                  default: ;
               endcase
         8: c[2*$urandom_range(0, 2)] = c[2*$urandom_range(0, 2)];
         9: for (int i = 1; i < 6; i += 2)
               c[i] = near_zero();
         default: ;
      endcase
      offer(c[0], c[1], c[2], c[3], c[4], c[5]);
   endtask

   initial begin : stimulus
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_first_x  <= '0;
      req_first_y  <= '0;
      req_second_x <= '0;
      req_second_y <= '0;
      req_third_x  <= '0;
      req_third_y  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // degenerate, flat, split and sort-order cases
      offer(0, 0, 0, 0, 0, 0);
      offer(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, 0, COORD_MAX);
      offer(COORD_MAX, COORD_MIN, -1, COORD_MIN, COORD_MIN, COORD_MIN);
      offer(-1, -1, -1, -1, -1, -1);
      offer(0, -100, 50, 100, -50, 100);
      offer(10, 0, 20, 40, 20, 40);
      offer(0, 100, -50, -100, 50, -100);
      offer(5, 5, 7, 5, 6, -20);
      offer(1, 7, 2, 7, 3, -7);
      offer(0, 0, 100, 50, 200, 300);
      offer(0, 0, -100, 50, -200, 300);
      offer(16, 0, 100, 32, 16, 64);
      offer(0, 0, 5, 1, -2, 3);
      offer(0, 0, 5, 1, 2, 3);
      offer(0, 0, 5, 5, 10, 10);
      offer(200, 300, 100, 50, 0, 0);
      offer(0, 10, 0, -10, 40, 0);
      offer(COORD_MIN, COORD_MIN, COORD_MAX, 0, COORD_MAX, COORD_MAX);
      offer(COORD_MAX, COORD_MIN, COORD_MIN, -32767, COORD_MIN, COORD_MAX);
      offer(COORD_MIN, COORD_MIN, 0, 32766, COORD_MAX, COORD_MAX);
      offer(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, 0, COORD_MAX);
      offer(0, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
      wait_drained();

      for (int n = 0; n < 2000; n++) begin
         if (n % 100 == 0)
            quiet_send = ($urandom_range(0, 3) == 0);
         if (n == 1000)
            wait_drained();
         offer_random();
      end
      wait_drained();
      repeat (CW + 8) @(posedge clock);

      if (tris_owed != 0)
         $error("%0d triangles never arrived", tris_owed);
      if (mismatches == 0 && tris_owed == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin : drain
      int   wait_cycles;
      int   beats;
      logic quiet_take;
      rsp_ready <= 1'b0;
      beats      = 0;
      quiet_take = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (beats % 64 == 0)
            quiet_take = ($urandom_range(0, 3) == 0);
         if (beats == HOLD_AT)
            wait_cycles = HOLD_CYCLES;
         else
            wait_cycles = quiet_take ? 0 : $urandom_range(0, 11);
         if (wait_cycles != 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         beats++;
      end
   end

endmodule
